### src/crcfc_pkg.sv
// Shared types, constants and the CRC-32 byte step for the frame checker.
// No dependencies; every other source file imports this package.

package crcfc_pkg;

	localparam int unsigned HDR_BYTES = 8;
	localparam int unsigned CRC_BYTES = 4;
	localparam int unsigned MIN_FRAME = HDR_BYTES + CRC_BYTES;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ALL  = 32'hFFFF_FFFF;

	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_VERSION = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_TYPE_CODE   = CFG_IDX_W'(1);

	localparam logic [7:0] PROTOCOL_VERSION_RST = 8'd1;
	localparam logic [7:0] DATA_TYPE_CODE_RST   = 8'd0;

	typedef enum logic [2:0] {
		STAT_OK          = 3'd0,
		STAT_TOO_SHORT   = 3'd1,
		STAT_BAD_VERSION = 3'd2,
		STAT_BAD_SIZE    = 3'd3,
		STAT_BAD_CRC     = 3'd4,
		STAT_BAD_TYPE    = 3'd5
	} frame_status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       rx_last;
	} rx_item_t;

	// One byte of reflected CRC-32, bit at a time.
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### src/crcfc_if.sv
// Channel interfaces: received bytes, check results and configuration writes.
// Depends on crcfc_pkg for the configuration field widths.

interface crcfc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       rx_last;

	modport source (output valid, output rx_byte, output rx_last, input ready);
	modport sink   (input valid, input rx_byte, input rx_last, output ready);
endinterface

interface crcfc_res_if;
	logic        valid;
	logic        ready;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic        frame_done;
	logic [2:0]  status;
	logic [15:0] seq_number;
	logic [31:0] payload_length;

	modport source (output valid, output payload_valid, output payload_byte,
		output frame_done, output status, output seq_number, output payload_length,
		input ready);
	modport sink (input valid, input payload_valid, input payload_byte,
		input frame_done, input status, input seq_number, input payload_length,
		output ready);
endinterface

interface crcfc_cfg_if import crcfc_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### src/crc32_frame_checker_top.sv
// Top level of the CRC-32 frame checker: input register plus checking core.
// Depends on crcfc_pkg, the crcfc interfaces, crcfc_in_reg and crcfc_core.

// The checker takes one received byte per transfer on rx, rx_last marking the
// end of a frame, and returns one result per byte on result. A frame is an
// 8-byte header (version, type, 16-bit sequence, 32-bit payload length, both
// little endian), the payload, and a little-endian reflected CRC-32 over
// header and payload. Payload bytes come out flagged by payload_valid as they
// arrive; the result for the last byte carries frame_done, the status and the
// decoded header fields, and the consumer must drop the payload unless the
// status is ok. Both sides may stall; throughput is one byte per clock
// while neither does. A byte passes the input register, then the CRC byte
// step (eight shift-and-xor steps) and the status compares run in one pass
// into the result register. Frames longer than MAX_PAYLOAD + 12 bytes
// saturate the byte counter and report a size mismatch unless the version
// is wrong. Write protocol_version (index 0) and data_type_code (index 1)
// on cfg only while no frame is in flight. No clearing pass after reset.

module crc32_frame_checker_top import crcfc_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	crcfc_rx_if.sink     rx,
	crcfc_res_if.source  result,
	crcfc_cfg_if.sink    cfg
);

	logic     valid_s1;
	rx_item_t item_s1;
	logic     core_ready;

	// Hold one byte ahead of the core so input and result stall independently.
	crcfc_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.down_ready (core_ready),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	// Advance frame state and load the result register on each transfer.
	crcfc_core #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_item  (item_s1),
		.in_ready (core_ready),
		.cfg      (cfg),
		.result   (result)
	);

endmodule

### src/crcfc_in_reg.sv
// Input register stage: captures one received byte per transfer.
// Depends on crcfc_pkg (rx_item_t) and crcfc_rx_if.

module crcfc_in_reg import crcfc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	crcfc_rx_if.sink  rx,
	input  logic      down_ready,
	output logic      valid_s1,
	output rx_item_t  item_s1
);

	logic take;

	// Refill when empty or whenever the held byte moves on in the same cycle.
	assign rx.ready = !valid_s1 || down_ready;
	assign take     = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (down_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{rx_byte: rx.rx_byte, rx_last: rx.rx_last};
		end
	end

endmodule

### src/crcfc_core.sv
// Frame state, header decode, CRC update, status checks and the result register.
// Depends on crcfc_pkg, crcfc_res_if and crcfc_cfg_if.

module crcfc_core import crcfc_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  rx_item_t    in_item,
	output logic        in_ready,
	crcfc_cfg_if.sink   cfg,
	crcfc_res_if.source result
);

	localparam int unsigned COUNT_CAP = MAX_PAYLOAD + HDR_BYTES + CRC_BYTES + 1;
	localparam int unsigned CNT_W     = $clog2(COUNT_CAP + 1);

	logic [7:0]       ver_q, type_code_q;
	logic [31:0]      crc_q, trl_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       hv_q, ht_q;
	logic [15:0]      hs_q;
	logic [31:0]      hl_q;
	logic             out_valid_q;

	logic [7:0]       b;
	logic [7:0]       hv_n, ht_n;
	logic [15:0]      hs_n;
	logic [31:0]      hl_n, crc_n, trl_n;
	logic [CNT_W-1:0] cnt_n;
	logic [32:0]      region_end;
	logic             below_end, below_cap, in_payload, take;
	frame_status_t    status_n;

	assign cfg.ready = 1'b1;
	assign in_ready  = !out_valid_q || result.ready;
	assign take      = in_valid && in_ready;
	assign b         = in_item.rx_byte;

	always_comb begin
		hv_n = (cnt_q == CNT_W'(0)) ? b : hv_q;
		ht_n = (cnt_q == CNT_W'(1)) ? b : ht_q;
		hs_n = hs_q;
		hl_n = hl_q;
		if (cnt_q == CNT_W'(2)) hs_n[7:0]   = b;
		if (cnt_q == CNT_W'(3)) hs_n[15:8]  = b;
		if (cnt_q == CNT_W'(4)) hl_n[7:0]   = b;
		if (cnt_q == CNT_W'(5)) hl_n[15:8]  = b;
		if (cnt_q == CNT_W'(6)) hl_n[23:16] = b;
		if (cnt_q == CNT_W'(7)) hl_n[31:24] = b;

		region_end = 33'(HDR_BYTES) + {1'b0, hl_n};
		below_end  = 33'(cnt_q) < region_end;
		below_cap  = cnt_q < CNT_W'(COUNT_CAP);
		in_payload = (cnt_q >= CNT_W'(HDR_BYTES)) && below_end && below_cap;

		crc_n = (below_end && below_cap) ? crc32_byte(crc_q, b) : crc_q;
		trl_n = {b, trl_q[31:8]};
		cnt_n = below_cap ? cnt_q + CNT_W'(1) : CNT_W'(COUNT_CAP);

		if (cnt_n < CNT_W'(MIN_FRAME)) begin
			status_n = STAT_TOO_SHORT;
		end else if (hv_n != ver_q) begin
			status_n = STAT_BAD_VERSION;
		end else if (cnt_n >= CNT_W'(COUNT_CAP)
				|| 34'(cnt_n) != 34'(region_end) + 34'(CRC_BYTES)) begin
			status_n = STAT_BAD_SIZE;
		end else if ((crc_n ^ CRC_ALL) != trl_n) begin
			status_n = STAT_BAD_CRC;
		end else if (ht_n != type_code_q) begin
			status_n = STAT_BAD_TYPE;
		end else begin
			status_n = STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ver_q       <= PROTOCOL_VERSION_RST;
			type_code_q <= DATA_TYPE_CODE_RST;
			crc_q       <= CRC_ALL;
			trl_q       <= '0;
			cnt_q       <= '0;
			hv_q        <= '0;
			ht_q        <= '0;
			hs_q        <= '0;
			hl_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == CFG_PROTOCOL_VERSION) ver_q <= cfg.data;
				if (cfg.index == CFG_DATA_TYPE_CODE)   type_code_q <= cfg.data;
			end
			if (take) begin
				out_valid_q <= 1'b1;
				if (in_item.rx_last) begin
					// Rearm for the next frame.
					crc_q <= CRC_ALL;
					trl_q <= '0;
					cnt_q <= '0;
					hv_q  <= '0;
					ht_q  <= '0;
					hs_q  <= '0;
					hl_q  <= '0;
				end else begin
					crc_q <= crc_n;
					trl_q <= trl_n;
					cnt_q <= cnt_n;
					hv_q  <= hv_n;
					ht_q  <= ht_n;
					hs_q  <= hs_n;
					hl_q  <= hl_n;
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result.payload_valid  <= in_payload;
			result.payload_byte   <= in_payload ? b : 8'h00;
			result.frame_done     <= in_item.rx_last;
			result.status         <= in_item.rx_last ? status_n : STAT_OK;
			result.seq_number     <= in_item.rx_last ? hs_n : 16'h0;
			result.payload_length <= in_item.rx_last ? hl_n : 32'h0;
		end
	end

	assign result.valid = out_valid_q;

endmodule

### src/crcfc_checker.sv
// Port-level assertions for the frame checker, bound to the top level.
// Depends on crcfc_pkg for status codes.

module crcfc_checker import crcfc_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = 1024
) (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        payload_valid,
	input logic [7:0]  payload_byte,
	input logic        frame_done,
	input logic [2:0]  status,
	input logic [15:0] seq_number,
	input logic [31:0] payload_length
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(payload_byte) && $stable(status)
			&& $stable(frame_done))
		else $error("result changed while stalled");

	a_mid_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !frame_done |-> status == STAT_OK && seq_number == 16'h0
			&& payload_length == 32'h0)
		else $error("frame fields set before the last byte");

	a_no_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !payload_valid |-> payload_byte == 8'h00)
		else $error("payload byte set outside the payload");

	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_done && status == STAT_OK
			|-> payload_length <= 32'(MAX_PAYLOAD) && !payload_valid)
		else $error("ok status on an oversize frame or a payload last byte");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> status <= STAT_BAD_TYPE)
		else $error("undefined status code");

endmodule

bind crc32_frame_checker_top crcfc_checker #(
	.MAX_PAYLOAD (MAX_PAYLOAD)
) u_crcfc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.payload_valid  (result.payload_valid),
	.payload_byte   (result.payload_byte),
	.frame_done     (result.frame_done),
	.status         (result.status),
	.seq_number     (result.seq_number),
	.payload_length (result.payload_length)
);
